// ----- rtl/core/etfvd_pkg.sv -----
package etfvd_pkg;

    localparam int unsigned HASH_W  = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned TAG_W   = 9;
    localparam int unsigned ENTRY_W = CNT_W + TAG_W;
    // ceil(len / 64) for a 16-bit length reaches 1024
    localparam int unsigned UNITS_W = LEN_W - 6 + 1;

    localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;
    localparam logic [CNT_W-1:0] THR_RESET = 7'd16;

    typedef enum logic
    {
        FUNC_PACKET = 1'b0,
        FUNC_TICK   = 1'b1
    } func_t;

    // per-item control carried down the pipeline
    typedef struct packed
    {
        func_t              func;
        logic [UNITS_W-1:0] units;
    } item_ctl_t;

    // outcome of one read-modify-write
    typedef struct packed
    {
        logic               flag;
        logic [ENTRY_W-1:0] entry;
    } upd_res_t;

endpackage

// ----- rtl/core/etfvd_in_if.sv -----
interface etfvd_in_if;
    import etfvd_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [HASH_W-1:0] flow_hash;
    logic [LEN_W-1:0]  pkt_length;

    modport source (output valid, output func, output flow_hash, output pkt_length,
                    input ready);
    modport sink   (input valid, input func, input flow_hash, input pkt_length,
                    output ready);
endinterface

// ----- rtl/core/etfvd_out_if.sv -----
interface etfvd_out_if;
    import etfvd_pkg::*;

    logic             valid;
    logic             ready;
    logic             over_threshold;
    logic [TAG_W-1:0] epoch_now;

    modport source (output valid, output over_threshold, output epoch_now, input ready);
    modport sink   (input valid, input over_threshold, input epoch_now, output ready);
endinterface

// ----- rtl/core/epoch_tagged_flow_volume_detector.sv -----
// Flow volume detector with a hashed counter table and epoch tags. Each packet
// (func 0) does one read-modify-write of the entry at flow_hash mod TABLE_DEPTH
// and returns over_threshold; a tick (func 1) advances the 9-bit epoch. One item
// is taken per clock while no result waits on result.ready; each item passes
// through the input register, two reciprocal-multiply stages for the index,
// one reduce stage, one table read, then the result register. Back-to-back
// packets to the same entry are served by a write bypass, so there is no stall
// between them. After reset the table is swept to zero, one entry a cycle,
// over all TABLE_DEPTH entries; item.ready stays low during that sweep. Write
// threshold_units through cfg_wr_en/cfg_wr_data only while no item is in flight.
module epoch_tagged_flow_volume_detector #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    etfvd_in_if.sink                   item,
    etfvd_out_if.source                result,
    input  logic                       cfg_wr_en,
    input  logic [etfvd_pkg::CNT_W-1:0] cfg_wr_data
);
    import etfvd_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    // stage 0 is the input register, stage 4 is the table read
    localparam int unsigned STAGES = 5;

    logic                 adv;
    logic                 accept;

    logic [CNT_W-1:0]     thr_reg;
    logic [TAG_W-1:0]     epoch_reg;
    logic [TAG_W-1:0]     epoch_next;

    logic                 clr_busy_reg;
    logic [IDX_W-1:0]     clr_cnt_reg;

    logic [STAGES-1:0]    v_reg;
    item_ctl_t            ctl_reg [STAGES];
    item_ctl_t            ctl_in;
    logic [HASH_W-1:0]    hash_reg;
    logic [IDX_W-1:0]     idx3;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 byp_v_reg;
    logic [IDX_W-1:0]     byp_idx_reg;
    logic [ENTRY_W-1:0]   byp_data_reg;
    logic [ENTRY_W-1:0]   entry_cur;
    upd_res_t             upd;
    logic                 pkt_fire;
    logic                 tick_fire;

    logic                 out_valid_reg;
    logic                 out_flag_reg;
    logic [TAG_W-1:0]     out_epoch_reg;

    // whole pipeline moves together; it holds only while a result waits
    assign adv    = !out_valid_reg || result.ready;
    assign accept = item.valid && item.ready;
    assign item.ready = adv && !clr_busy_reg;

    assign ctl_in.func  = func_t'(item.func);
    assign ctl_in.units = UNITS_W'(item.pkt_length[LEN_W-1:6]) +
                          UNITS_W'(|item.pkt_length[5:0]);

    etfvd_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .clk  (clk),
        .en   (adv),
        .hash (hash_reg),
        .idx  (idx3)
    );

    // hold the read address while stalled so the read data stays current
    assign ram_raddr = adv ? idx3 : rd_idx_reg;

    etfvd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // forward the write made in the same cycle the entry was read
    assign entry_cur = (byp_v_reg && byp_idx_reg == rd_idx_reg) ? byp_data_reg : ram_rdata;

    etfvd_update u_update (
        .entry     (entry_cur),
        .epoch     (epoch_reg),
        .threshold (thr_reg),
        .units     (ctl_reg[STAGES-1].units),
        .res       (upd)
    );

    assign pkt_fire  = adv && v_reg[STAGES-1] && ctl_reg[STAGES-1].func == FUNC_PACKET;
    assign tick_fire = adv && v_reg[STAGES-1] && ctl_reg[STAGES-1].func == FUNC_TICK;
    assign epoch_next = epoch_reg + TAG_W'(1);

    assign ram_we    = clr_busy_reg || pkt_fire;
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : rd_idx_reg;
    assign ram_wdata = clr_busy_reg ? '0 : upd.entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            epoch_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            v_reg         <= '0;
            byp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                v_reg         <= {v_reg[STAGES-2:0], accept};
                out_valid_reg <= v_reg[STAGES-1];
            end
            if (tick_fire)
            begin
                epoch_reg <= epoch_next;
            end
            if (pkt_fire)
            begin
                byp_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < STAGES; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            hash_reg   <= item.flow_hash;
            rd_idx_reg <= idx3;
            if (v_reg[STAGES-1])
            begin
                out_flag_reg  <= pkt_fire && upd.flag;
                out_epoch_reg <= tick_fire ? epoch_next : epoch_reg;
            end
        end
        if (pkt_fire)
        begin
            byp_idx_reg  <= rd_idx_reg;
            byp_data_reg <= upd.entry;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.over_threshold = out_flag_reg;
    assign result.epoch_now      = out_epoch_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !item.ready)
        else $error("item accepted during table sweep");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (ram_we && ram_wdata == '0 && !pkt_fire))
        else $error("table sweep write is not a zero entry");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> epoch_reg == $past(epoch_reg) + TAG_W'(1))
        else $error("tick did not advance the epoch by one");

    a_packet_keeps_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_fire |=> $stable(epoch_reg))
        else $error("epoch moved without a tick");

    a_tag_is_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_fire |-> ram_wdata[TAG_W-1:0] == epoch_reg)
        else $error("written tag differs from the current epoch");
endmodule

// ----- rtl/core/etfvd_ram.sv -----
module etfvd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/etfvd_index.sv -----
module etfvd_index #(
    parameter int unsigned TABLE_DEPTH = 1024,
    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [etfvd_pkg::HASH_W-1:0] hash,
    output logic [IDX_W-1:0]            idx
);
    import etfvd_pkg::*;

    // remainder after the reciprocal estimate stays below twice the depth
    localparam int unsigned REM_W = IDX_W + 1;
    localparam logic [HASH_W-1:0] RECIP   = HASH_W'((64'd1 << HASH_W) / TABLE_DEPTH);
    localparam logic [HASH_W-1:0] DEPTH_H = HASH_W'(TABLE_DEPTH);
    localparam logic [REM_W-1:0]  DEPTH_R = REM_W'(TABLE_DEPTH);

    logic [2*HASH_W-1:0] prod;
    logic [HASH_W-1:0]   quot_reg;
    logic [HASH_W-1:0]   hash1_reg;
    logic [HASH_W-1:0]   qd_reg;
    logic [HASH_W-1:0]   hash2_reg;
    logic [HASH_W-1:0]   diff;
    logic [REM_W-1:0]    rem;
    logic [REM_W-1:0]    rem_fix;
    logic [IDX_W-1:0]    idx_reg;

    assign prod    = (2*HASH_W)'(hash) * (2*HASH_W)'(RECIP);
    assign diff    = hash2_reg - qd_reg;
    assign rem     = diff[REM_W-1:0];
    assign rem_fix = (rem >= DEPTH_R) ? rem - DEPTH_R : rem;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient estimate, low by at most one
            quot_reg  <= prod[2*HASH_W-1:HASH_W];
            hash1_reg <= hash;
            qd_reg    <= quot_reg * DEPTH_H;
            hash2_reg <= hash1_reg;
            idx_reg   <= rem_fix[IDX_W-1:0];
        end
    end

    assign idx = idx_reg;
endmodule

// ----- rtl/core/etfvd_update.sv -----
module etfvd_update (
    input  logic [etfvd_pkg::ENTRY_W-1:0] entry,
    input  logic [etfvd_pkg::TAG_W-1:0]   epoch,
    input  logic [etfvd_pkg::CNT_W-1:0]   threshold,
    input  logic [etfvd_pkg::UNITS_W-1:0] units,
    output etfvd_pkg::upd_res_t           res
);
    import etfvd_pkg::*;

    logic [CNT_W-1:0]   cnt;
    logic [TAG_W-1:0]   tag;
    logic [TAG_W-1:0]   lag;
    logic [CNT_W-1:0]   cnt_live;
    logic [CNT_W-1:0]   limit;
    logic               flag;
    logic [UNITS_W:0]   sum;
    logic [CNT_W-1:0]   cnt_sat;

    assign cnt = entry[ENTRY_W-1:TAG_W];
    assign tag = entry[TAG_W-1:0];
    // wraps modulo the tag range
    assign lag = epoch - tag;
    assign cnt_live = (lag > TAG_W'(1)) ? '0 : cnt;
    assign limit = (threshold == '0) ? '0 : threshold - CNT_W'(1);
    assign flag = (cnt_live >= limit);
    assign sum = (UNITS_W + 1)'(cnt_live) + (UNITS_W + 1)'(units);
    assign cnt_sat = (sum > (UNITS_W + 1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];

    always_comb
    begin
        res.flag  = flag;
        res.entry = {(flag ? cnt_live : cnt_sat), epoch};
    end
endmodule
